/* rtl/nps_pkg.sv */
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants for the monophonic note priority stack.
// ----------------------------------------------------------------------------
package nps_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int NOTE_W      = 7;
   localparam int VEL_W       = 7;
   localparam int ACT_W       = 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_VOICE_ON  = 2'd0,
      ACT_VOICE_OFF = 2'd1,
      ACT_LEGATO    = 2'd2
   } action_type;

   typedef enum logic [0:0] {
      OP_NOTE_ON  = 1'b0,
      OP_NOTE_OFF = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_SHIFT  = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

endpackage

/* rtl/nps_ram.sv */
// ----------------------------------------------------------------------------
// nps_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mono_note_priority_stack_top.sv */
// ----------------------------------------------------------------------------
// mono_note_priority_stack_top
// Last-note-priority held-note stack driving a monophonic voice.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries note events (op, note, velocity). A note-on with
//   nonzero velocity pushes the note and returns a voice-on beat. A note-off
//   with at most one key held returns voice-off; releasing the top note returns a
//   legato retrigger of the note below it; releasing a deeper note removes it
//   silently. Events that return nothing simply complete.
//   The rsp channel carries (action, voice_note) beats from an output
//   register; a stalled beat holds until taken.
//   A note-on, or a note-off with at most one key held, is taken without a
//   stall; its beat goes straight to the output register when that is free,
//   else it waits in the staging register. A note-off with more keys held
//   walks the stack RAM one entry per cycle through its single read port
//   and keeps req_stall high until it has searched up to a lower match and
//   shifted the rest down, ended in a legato beat, or found that the note
//   is not held at all. req_stall is also high while a result waits in the
//   staging register for a stalled output.
//   Reset clears the held count and the handshake state; the stack RAM is not
//   cleared, entries are written before they are read.
// ----------------------------------------------------------------------------
module mono_note_priority_stack_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_op,
   input  logic [nps_pkg::NOTE_W-1:0] req_note,
   input  logic [nps_pkg::VEL_W-1:0]  req_velocity,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [nps_pkg::ACT_W-1:0]  rsp_action,
   output logic [nps_pkg::NOTE_W-1:0] rsp_voice_note
);

   import nps_pkg::*;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] chk_ff, chk_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [NOTE_W-1:0] note_ff, note_in;
   logic [NOTE_W-1:0] prev_ff, prev_in;
   action_type        pend_act_ff, pend_act_in;
   logic [NOTE_W-1:0] pend_note_ff, pend_note_in;

   logic              rsp_valid_ff, rsp_valid_in;
   action_type        rsp_action_ff, rsp_action_in;
   logic [NOTE_W-1:0] rsp_note_ff, rsp_note_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [NOTE_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [NOTE_W-1:0] rd_data;

   logic              accept;
   logic              out_free;
   logic              load;
   action_type        load_act;
   logic [NOTE_W-1:0] load_note;
   logic              match;

   nps_ram #(
      .WIDTH(NOTE_W),
      .DEPTH(STACK_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign match     = (rd_data == note_ff);
   assign rd_addr   = addr_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      chk_in       = chk_ff;
      chk_vld_in   = chk_vld_ff;
      note_in      = note_ff;
      prev_in      = prev_ff;
      pend_act_in  = pend_act_ff;
      pend_note_in = pend_note_ff;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff;
      wr_data      = req_note;
      load         = 1'b0;
      load_act     = ACT_VOICE_ON;
      load_note    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_NOTE_ON) begin
                  if (req_velocity != '0) begin
                     wr_en = 1'b1;
                     if (cnt_ff != ADDR_W'(STACK_DEPTH - 1)) begin
                        cnt_in = cnt_ff + ADDR_W'(1);
                     end
                     load_act  = ACT_VOICE_ON;
                     load_note = req_note;
                     load      = 1'b1;
                  end
               end else if (cnt_ff <= ADDR_W'(1)) begin
                  cnt_in    = '0;
                  load_act  = ACT_VOICE_OFF;
                  load_note = '0;
                  load      = 1'b1;
               end else begin
                  cnt_in     = cnt_ff - ADDR_W'(1);
                  note_in    = req_note;
                  addr_in    = '0;
                  chk_vld_in = 1'b0;
                  state_in   = ST_SEARCH;
               end
               // park the result when the output register is still held
               if (load && !out_free) begin
                  load         = 1'b0;
                  pend_act_in  = load_act;
                  pend_note_in = load_note;
                  state_in     = ST_EMIT;
               end
            end
         end

         ST_SEARCH: begin
            // advance the read pointer; data for chk_ff is on rd_data
            addr_in    = addr_ff + ADDR_W'(1);
            chk_in     = addr_ff;
            chk_vld_in = 1'b1;
            if (chk_vld_ff) begin
               prev_in = rd_data;
               if (chk_ff != cnt_ff) begin
                  if (match) begin
                     addr_in    = chk_ff + ADDR_W'(1);
                     chk_vld_in = 1'b0;
                     state_in   = ST_SHIFT;
                  end
               end else if (match) begin
                  pend_act_in  = ACT_LEGATO;
                  pend_note_in = prev_ff;
                  state_in     = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SHIFT: begin
            // copy entry k down to k-1, one per cycle, up to the count
            addr_in    = addr_ff + ADDR_W'(1);
            chk_in     = addr_ff;
            chk_vld_in = 1'b1;
            if (chk_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = chk_ff - ADDR_W'(1);
               wr_data = rd_data;
               if (chk_ff == cnt_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               load_act  = pend_act_ff;
               load_note = pend_note_ff;
               load      = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !out_free;
      rsp_action_in = rsp_action_ff;
      rsp_note_in   = rsp_note_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_action_in = load_act;
         rsp_note_in   = load_note;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      chk_ff        <= chk_in;
      note_ff       <= note_in;
      prev_ff       <= prev_in;
      pend_act_ff   <= pend_act_in;
      pend_note_ff  <= pend_note_in;
      rsp_action_ff <= rsp_action_in;
      rsp_note_ff   <= rsp_note_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = rsp_action_ff;
   assign rsp_voice_note = rsp_note_ff;

endmodule
